/* rtl/ttc_pkg.sv */
// Shared types and constants for the tile id to tileset cell decoder.
package ttc_pkg;

    // Field widths fixed by the interface
    localparam int ID_W    = 16;
    localparam int COLS_W  = 11;
    localparam int SIZE_W  = 9;
    localparam int MAP_W   = 10;
    localparam int PIX_W   = 18;
    localparam int SCOL_W  = 10;
    localparam int SET_W   = 3;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 4;
    localparam int BOUND_W = 3 * ID_W;
    localparam int SHAPE_W = COLS_W + SIZE_W;
    localparam int DSTEP_W = 5;

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Register byte addresses
    localparam logic [1:0] ADDR_TILESET_COUNT = 2'd0;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHAPE,
        S_SHAPE_W,
        S_DIV,
        S_OUT
    } t_state;

    // Divider result bundle
    typedef struct packed {
        logic              done;
        logic [ID_W-1:0]   quot;
        logic [COLS_W-1:0] rem;
    } t_div_res;

endpackage

/* rtl/ttc_ram.sv */
// Generic single write port RAM with registered read.
module ttc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ttc_div.sv */
// Restoring divider: 16-bit id by 11-bit column count, one quotient bit per cycle.
module ttc_div
    import ttc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ID_W-1:0]   i_dividend,
    input  logic [COLS_W-1:0] i_divisor,
    output t_div_res          o_res
);

    logic                r_busy;
    logic                r_done;
    logic [DSTEP_W-1:0]  r_cnt;
    logic [ID_W-1:0]     r_quot;
    logic [COLS_W-1:0]   r_rem;
    logic [COLS_W-1:0]   r_div;
    logic [COLS_W:0]     trial;
    logic [COLS_W:0]     diff;
    logic                ge;

    // one trial subtract per cycle
    assign trial = {r_rem, r_quot[ID_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DSTEP_W'(1);
                if (r_cnt == DSTEP_W'(ID_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[ID_W-2:0], ge};
            r_rem  <= ge ? diff[COLS_W-1:0] : trial[COLS_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

/* rtl/tile_id_to_tileset_cell.sv */
// Tile id to tileset cell decoder: top level with slot tables and sequencer.
//
// Input channel (i_valid / o_stall) carries one command word per accept.
// A write command stores one tileset slot (if i_slot_index < MAX_TILESETS)
// and gives no result. A decode command with a nonzero tile id searches
// slots 1 up to min(tileset_count, MAX_TILESETS)-1 until a hit, one slot
// per S_SRCH/S_CMP pass through the slot table's read port, then divides
// the (remapped) id by the column count in a restoring divider, one
// quotient bit per cycle. A decode of id 0 gives no result and never
// stalls the input. The block takes one decode at a time and holds o_stall
// high until that item's result sits in the output register.
// Output channel (o_valid / i_stall): the result register holds its word
// while i_stall is high; the next item may be accepted and worked on
// meanwhile and waits at the end for the register to free up.
// Reset clears the sequencer, the output valid and tileset_count (to 1);
// the slot tables are undefined until written.
// APB port: register tileset_count at byte address 0, pready always high.
module tile_id_to_tileset_cell
    import ttc_pkg::*;
#(
    parameter int MAX_TILESETS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [SLOT_W-1:0]   i_slot_index,
    input  logic [ID_W-1:0]     i_first_id,
    input  logic [ID_W-1:0]     i_last_id,
    input  logic [ID_W-1:0]     i_tile_count,
    input  logic [COLS_W-1:0]   i_set_columns,
    input  logic [SIZE_W-1:0]   i_set_tile_size,
    input  logic [ID_W-1:0]     i_tile_id,
    input  logic [MAP_W-1:0]    i_map_row,
    input  logic [MAP_W-1:0]    i_map_col,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SET_W-1:0]    o_set_index,
    output logic [PIX_W-1:0]    o_pixel_x,
    output logic [PIX_W-1:0]    o_pixel_y,
    output logic [ID_W-1:0]     o_source_row,
    output logic [SCOL_W-1:0]   o_source_col,
    output logic [SIZE_W-1:0]   o_draw_size,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;
    localparam int KW = $clog2(MAX_TILESETS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_tcount;
    logic [KW-1:0]       r_k;
    logic [AW-1:0]       r_chosen;
    logic [ID_W-1:0]     r_id;
    logic [MAP_W-1:0]    r_map_row;
    logic [MAP_W-1:0]    r_map_col;
    logic [COLS_W-1:0]   r_cols;
    logic [SIZE_W-1:0]   r_size;
    logic [PIX_W-1:0]    r_px;
    logic [PIX_W-1:0]    r_py;
    logic [ID_W-1:0]     r_row;
    logic [SCOL_W-1:0]   r_col;

    logic                r_o_valid;
    logic [SET_W-1:0]    r_o_set_index;
    logic [PIX_W-1:0]    r_o_pixel_x;
    logic [PIX_W-1:0]    r_o_pixel_y;
    logic [ID_W-1:0]     r_o_source_row;
    logic [SCOL_W-1:0]   r_o_source_col;
    logic [SIZE_W-1:0]   r_o_draw_size;

    logic                in_acc;
    logic                out_acc;
    logic                cfg_wr;
    logic                slot_we;
    logic [7:0]          used8;
    logic [7:0]          cnt8;
    logic                more_slots;
    logic                hit;
    logic                div_start;
    logic                load_out;

    logic [BOUND_W-1:0]  bnd_rdata;
    logic [SHAPE_W-1:0]  shp_rdata;
    logic [ID_W-1:0]     b_lo, b_hi, b_cnt;
    logic [COLS_W-1:0]   shp_cols;
    logic [SIZE_W-1:0]   shp_size;
    logic [ID_W-1:0]     remap_id;
    logic [PIX_W:0]      px_full, py_full;
    t_div_res            div_res;

    // handshakes
    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_o_valid && !i_stall;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TILESET_COUNT);
    assign prdata = (paddr == ADDR_TILESET_COUNT) ? {{(32-CNT_W){1'b0}}, r_tcount} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcount <= CNT_W'(1);
        end else if (cfg_wr) begin
            r_tcount <= pwdata[CNT_W-1:0];
        end
    end

    // slots in use, clamped to the table depth
    assign cnt8       = {{(8-CNT_W){1'b0}}, r_tcount};
    assign used8      = (cnt8 > 8'(MAX_TILESETS)) ? 8'(MAX_TILESETS) : cnt8;
    assign more_slots = (8'(r_k) < used8);

    // slot tables
    assign slot_we = in_acc && (i_command == CMD_WRITE) &&
                     ({5'd0, i_slot_index} < 8'(MAX_TILESETS));

    ttc_ram #(
        .WIDTH (BOUND_W),
        .DEPTH (MAX_TILESETS)
    ) u_bounds (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (AW'(i_slot_index)),
        .i_wdata ({i_tile_count, i_last_id, i_first_id}),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (bnd_rdata)
    );

    ttc_ram #(
        .WIDTH (SHAPE_W),
        .DEPTH (MAX_TILESETS)
    ) u_shape (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (AW'(i_slot_index)),
        .i_wdata ({i_set_tile_size, i_set_columns}),
        .i_raddr (r_chosen),
        .o_rdata (shp_rdata)
    );

    // slot compare and id remap
    assign b_lo     = bnd_rdata[ID_W-1:0];
    assign b_hi     = bnd_rdata[2*ID_W-1:ID_W];
    assign b_cnt    = bnd_rdata[3*ID_W-1:2*ID_W];
    assign hit      = (r_id > b_lo) && (r_id < b_hi);
    assign remap_id = r_id + b_cnt - b_hi;

    // shape fields; zero columns act as one
    assign shp_cols = (shp_rdata[COLS_W-1:0] == '0) ? COLS_W'(1) : shp_rdata[COLS_W-1:0];
    assign shp_size = shp_rdata[SHAPE_W-1:COLS_W];
    assign px_full  = {{(PIX_W+1-MAP_W){1'b0}}, r_map_col} *
                      {{(PIX_W+1-SIZE_W){1'b0}}, shp_size};
    assign py_full  = {{(PIX_W+1-MAP_W){1'b0}}, r_map_row} *
                      {{(PIX_W+1-SIZE_W){1'b0}}, shp_size};

    ttc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_id),
        .i_divisor  (shp_cols),
        .o_res      (div_res)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_command == CMD_DECODE) && (i_tile_id != '0)) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_state = more_slots ? S_CMP : S_SHAPE;
            end
            S_CMP: begin
                n_state = hit ? S_SHAPE : S_SRCH;
            end
            S_SHAPE: begin
                n_state = S_SHAPE_W;
            end
            S_SHAPE_W: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id      <= i_tile_id;
            r_map_row <= i_map_row;
            r_map_col <= i_map_col;
            r_k       <= KW'(1);
            r_chosen  <= '0;
        end
        if (r_state == S_CMP) begin
            if (hit) begin
                r_id     <= remap_id;
                r_chosen <= r_k[AW-1:0];
            end else begin
                r_k <= r_k + KW'(1);
            end
        end
        if (r_state == S_SHAPE_W) begin
            r_cols <= shp_cols;
            r_size <= shp_size;
            r_px   <= px_full[PIX_W-1:0];
            r_py   <= py_full[PIX_W-1:0];
        end
        // exact multiple of columns: last column of the previous row
        if ((r_state == S_DIV) && div_res.done) begin
            if (div_res.rem == '0) begin
                r_row <= div_res.quot - ID_W'(1);
                r_col <= SCOL_W'(r_cols - COLS_W'(1));
            end else begin
                r_row <= div_res.quot;
                r_col <= SCOL_W'(div_res.rem - COLS_W'(1));
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (out_acc) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_set_index  <= SET_W'(r_chosen);
            r_o_pixel_x    <= r_px;
            r_o_pixel_y    <= r_py;
            r_o_source_row <= r_row;
            r_o_source_col <= r_col;
            r_o_draw_size  <= r_size;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_set_index  = r_o_set_index;
    assign o_pixel_x    = r_o_pixel_x;
    assign o_pixel_y    = r_o_pixel_y;
    assign o_source_row = r_o_source_row;
    assign o_source_col = r_o_source_col;
    assign o_draw_size  = r_o_draw_size;

`ifndef NO_ASSERTIONS
    // a nonzero decode always starts the slot search
    a_decode_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_DECODE) && (i_tile_id != '0)) |=> (r_state == S_SRCH))
        else $error("decode accept did not start search");

    // compare only follows a read issued in the search state
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_SRCH))
        else $error("compare without slot read");

    // divider finishes only while the sequencer waits on it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider done outside wait state");

    // chosen slot lies within the slots in use
    a_chosen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHAPE) |-> ((r_chosen == '0) || (8'(r_chosen) < used8)))
        else $error("chosen slot out of range");

    // output register is loaded only when free or being emptied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_o_valid || !i_stall))
        else $error("result overwritten");
`endif

endmodule
